@@ src/kwm_pkg.sv @@
package kwm_pkg;

    localparam int NUM_LISTS  = 8;
    localparam int LIST_DEPTH = 64;

    localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int PTR_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W  = PTR_W + 1;
    localparam int ADDR_W = LIST_W + PTR_W;
    localparam int MEM_DEPTH = NUM_LISTS * (2 ** PTR_W);
    localparam int TREE_N = 2 ** LIST_W;

    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // candidate head carried through the selection tree
    typedef struct packed {
        logic                      found;
        logic [LIST_W-1:0]         idx;
        logic signed [VALUE_W-1:0] value;
    } kwm_pick_t;

endpackage

@@ src/kwm_list_mem.sv @@
module kwm_list_mem
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [kwm_pkg::ADDR_W-1:0]    wr_addr,
    input  logic [kwm_pkg::VALUE_W-1:0]   wr_data,
    input  logic                          rd_en,
    input  logic [kwm_pkg::ADDR_W-1:0]    rd_addr,
    output logic [kwm_pkg::VALUE_W-1:0]   rd_data
);

    logic [kwm_pkg::VALUE_W-1:0] mem [kwm_pkg::MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/kwm_min_tree.sv @@
module kwm_min_tree
(
    input  logic [kwm_pkg::VALUE_W-1:0] heads [kwm_pkg::NUM_LISTS],
    input  logic [kwm_pkg::NUM_LISTS-1:0] head_valid,
    output kwm_pkg::kwm_pick_t          pick
);

    kwm_pkg::kwm_pick_t node [2*kwm_pkg::TREE_N];

    // heap layout: leaves at TREE_N + k, root at 1; ties keep the left (lower) list
    always_comb
    begin
        node[0] = '0;
        for (int k = 0; k < kwm_pkg::TREE_N; k++)
        begin
            node[kwm_pkg::TREE_N + k].idx = kwm_pkg::LIST_W'(k);
            if (k < kwm_pkg::NUM_LISTS)
            begin
                node[kwm_pkg::TREE_N + k].found = head_valid[k];
                node[kwm_pkg::TREE_N + k].value = $signed(heads[k]);
            end
            else
            begin
                node[kwm_pkg::TREE_N + k].found = 1'b0;
                node[kwm_pkg::TREE_N + k].value = '0;
            end
        end
        for (int i = kwm_pkg::TREE_N - 1; i >= 1; i--)
        begin
            if (node[2*i+1].found &&
                (!node[2*i].found ||
                 ($signed(node[2*i+1].value) < $signed(node[2*i].value))))
            begin
                node[i] = node[2*i+1];
            end
            else
            begin
                node[i] = node[2*i];
            end
        end
        pick = node[1];
    end

endmodule

@@ src/k_way_sorted_merge.sv @@
// k-way merge of ascending lists.
// Input stream s_*: one transaction per command. kind 0 appends element_value
// to list list_index (dropped when the list is full or does not exist),
// kind 1 pops the smallest head over all lists, kind 2 empties every list,
// kind 3 is ignored.
// Output stream m_*: one transaction per pop, with the value and its source
// list in m_tdata and the all-empty flag in m_tuser. Equal heads go to the
// lowest list number.
// The head of every list is cached in flops; the values sit in one
// synchronous RAM of NUM_LISTS x LIST_DEPTH words. A push needs no refill.
// A pop that leaves values behind in its list stalls the input: the minimum is
// chosen and registered in the accept cycle, and the next cycle refills the
// taken head from the RAM read port, with s_tready low. A pop that drains its
// list or finds every list empty needs no refill. The pop result is visible
// on m_* in the cycle after the transaction is accepted.
// The output register holds one result; while it is full and m_tready is
// low, s_tready is low too.
// Reset empties all lists at once (counters only, no clearing pass); the RAM
// keeps its contents, and stale entries are never read.
module k_way_sorted_merge
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // kind[1:0], list_index[4:2], element_value[36:5]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // smallest_value[31:0], source_list[34:32]
    output logic        m_tuser    // all_empty[0]
);

    localparam int NL = kwm_pkg::NUM_LISTS;

    logic [kwm_pkg::CNT_W-1:0]   wr_cnt_reg  [NL];
    logic [kwm_pkg::CNT_W-1:0]   wr_cnt_next [NL];
    logic [kwm_pkg::CNT_W-1:0]   rd_cnt_reg  [NL];
    logic [kwm_pkg::CNT_W-1:0]   rd_cnt_next [NL];
    logic [kwm_pkg::VALUE_W-1:0] head_reg    [NL];
    logic [kwm_pkg::VALUE_W-1:0] head_next   [NL];
    logic [NL-1:0]               head_valid;

    logic                        refill_reg;
    logic                        refill_next;
    logic [kwm_pkg::LIST_W-1:0]  refill_list_reg;
    logic [kwm_pkg::LIST_W-1:0]  refill_list_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [kwm_pkg::VALUE_W-1:0] out_value_reg;
    logic [kwm_pkg::VALUE_W-1:0] out_value_next;
    logic [2:0]                  out_list_reg;
    logic [2:0]                  out_list_next;
    logic                        out_empty_reg;
    logic                        out_empty_next;

    logic                        accept;
    kwm_pkg::kind_t              in_kind;
    logic [2:0]                  in_list;
    logic [kwm_pkg::VALUE_W-1:0] in_value;
    logic [kwm_pkg::LIST_W-1:0]  push_id;
    logic                        push_ok;
    logic [kwm_pkg::CNT_W-1:0]   pop_rd_inc;

    kwm_pkg::kwm_pick_t          pick;

    logic                        mem_wr_en;
    logic [kwm_pkg::ADDR_W-1:0]  mem_wr_addr;
    logic                        mem_rd_en;
    logic [kwm_pkg::ADDR_W-1:0]  mem_rd_addr;
    logic [kwm_pkg::VALUE_W-1:0] mem_rd_data;

    assign in_kind  = kwm_pkg::kind_t'(s_tdata[1:0]);
    assign in_list  = s_tdata[4:2];
    assign in_value = s_tdata[36:5];
    assign push_id  = kwm_pkg::LIST_W'(in_list);

    assign s_tready = !refill_reg && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        for (int k = 0; k < NL; k++)
        begin
            head_valid[k] = (rd_cnt_reg[k] != wr_cnt_reg[k]);
        end
    end

    kwm_min_tree u_min_tree
    (
        .heads      (head_reg),
        .head_valid (head_valid),
        .pick       (pick)
    );

    assign push_ok = (int'(in_list) < NL) &&
                     (int'(wr_cnt_reg[push_id]) < kwm_pkg::LIST_DEPTH);
    assign pop_rd_inc = rd_cnt_reg[pick.idx] + kwm_pkg::CNT_W'(1);

    always_comb
    begin
        for (int k = 0; k < NL; k++)
        begin
            wr_cnt_next[k] = wr_cnt_reg[k];
            rd_cnt_next[k] = rd_cnt_reg[k];
            head_next[k]   = head_reg[k];
        end
        refill_next      = 1'b0;
        refill_list_next = refill_list_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_value_next   = out_value_reg;
        out_list_next    = out_list_reg;
        out_empty_next   = out_empty_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = {push_id, wr_cnt_reg[push_id][kwm_pkg::PTR_W-1:0]};
        mem_rd_en        = 1'b0;
        mem_rd_addr      = {pick.idx, pop_rd_inc[kwm_pkg::PTR_W-1:0]};

        // head comes back from the RAM in the cycle after the pop
        if (refill_reg)
        begin
            head_next[refill_list_reg] = mem_rd_data;
        end

        if (accept)
        begin
            unique case (in_kind)
                kwm_pkg::KIND_PUSH:
                begin
                    if (push_ok)
                    begin
                        mem_wr_en            = 1'b1;
                        wr_cnt_next[push_id] = wr_cnt_reg[push_id] + kwm_pkg::CNT_W'(1);
                        // empty list: the new value is the head at once
                        if (rd_cnt_reg[push_id] == wr_cnt_reg[push_id])
                        begin
                            head_next[push_id] = in_value;
                        end
                    end
                end
                kwm_pkg::KIND_POP:
                begin
                    out_valid_next = 1'b1;
                    if (pick.found)
                    begin
                        rd_cnt_next[pick.idx] = pop_rd_inc;
                        out_value_next = pick.value;
                        out_list_next  = 3'(pick.idx);
                        out_empty_next = 1'b0;
                        if (pop_rd_inc != wr_cnt_reg[pick.idx])
                        begin
                            mem_rd_en        = 1'b1;
                            refill_next      = 1'b1;
                            refill_list_next = pick.idx;
                        end
                    end
                    else
                    begin
                        out_value_next = '0;
                        out_list_next  = '0;
                        out_empty_next = 1'b1;
                    end
                end
                kwm_pkg::KIND_CLEAR:
                begin
                    for (int k = 0; k < NL; k++)
                    begin
                        wr_cnt_next[k] = '0;
                        rd_cnt_next[k] = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    kwm_list_mem u_list_mem
    (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (in_value),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NL; k++)
            begin
                wr_cnt_reg[k] <= '0;
                rd_cnt_reg[k] <= '0;
            end
            refill_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < NL; k++)
            begin
                wr_cnt_reg[k] <= wr_cnt_next[k];
                rd_cnt_reg[k] <= rd_cnt_next[k];
            end
            refill_reg    <= refill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NL; k++)
        begin
            head_reg[k] <= head_next[k];
        end
        refill_list_reg <= refill_list_next;
        out_value_reg   <= out_value_next;
        out_list_reg    <= out_list_next;
        out_empty_reg   <= out_empty_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_list_reg, out_value_reg};
    assign m_tuser  = out_empty_reg;

endmodule

@@ sim/tb_k_way_sorted_merge.sv @@
`timescale 1ns / 1ps

module tb_k_way_sorted_merge;

    localparam int RAND_CMDS = 790;
    localparam int N_DIR     = 25;

    typedef struct {
        logic signed [31:0] value;
        logic [2:0]         src;
        logic               empty;
    } merge_out_t;

    typedef struct {
        kwm_pkg::kind_t kind;
        logic [2:0]     idx;
        logic [31:0]    val;
        bit             typed;   // expectation given in the row itself
        merge_out_t     res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;     // kind[1:0], list_index[4:2], element_value[36:5]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;     // smallest_value[31:0], source_list[34:32]
    logic        m_tuser;     // all_empty[0]

    // shadow of the list buffers
    logic [31:0] list_mem [kwm_pkg::NUM_LISTS][kwm_pkg::LIST_DEPTH];
    int          push_cnt [kwm_pkg::NUM_LISTS];
    int          pop_cnt  [kwm_pkg::NUM_LISTS];

    merge_out_t  pop_results_q[$];
    merge_out_t  mon_exp;

    // ascending-value generator per list
    int          seq_last    [kwm_pkg::NUM_LISTS];
    bit          seq_started [kwm_pkg::NUM_LISTS];

    bit          idle_en = 1'b1;
    int          errors = 0;
    int          n_cmds = 0;
    int          n_pops = 0;
    int          n_empty_pops = 0;
    int          n_drops = 0;
    int          n_clears = 0;
    int          n_results = 0;

    dir_row_t dir_rows [N_DIR] = '{
        '{kwm_pkg::KIND_POP,   3'd0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 3'd0, 1'b1}},
        '{kwm_pkg::KIND_NONE,  3'd7, 32'hFFFF_FFFF, 1'b0, '{32'h0, 3'd0, 1'b0}},
        '{kwm_pkg::KIND_POP,   3'd0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 3'd0, 1'b1}},
        '{kwm_pkg::KIND_PUSH,  3'd7, 32'h7FFF_FFFF, 1'b0, '{32'h0, 3'd0, 1'b0}},
        '{kwm_pkg::KIND_PUSH,  3'd0, 32'h8000_0000, 1'b0, '{32'h0, 3'd0, 1'b0}},
        '{kwm_pkg::KIND_PUSH,  3'd3, 32'h0000_0000, 1'b0, '{32'h0, 3'd0, 1'b0}},
        '{kwm_pkg::KIND_PUSH,  3'd0, 32'hFFFF_FFFF, 1'b0, '{32'h0, 3'd0, 1'b0}},
        '{kwm_pkg::KIND_PUSH,  3'd5, 32'h0000_0000, 1'b0, '{32'h0, 3'd0, 1'b0}},
        '{kwm_pkg::KIND_POP,   3'd0, 32'h0000_0000, 1'b1, '{32'h8000_0000, 3'd0, 1'b0}},
        '{kwm_pkg::KIND_POP,   3'd0, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 3'd0, 1'b0}},
        // equal heads: lower list wins
        '{kwm_pkg::KIND_POP,   3'd0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 3'd3, 1'b0}},
        '{kwm_pkg::KIND_POP,   3'd0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 3'd5, 1'b0}},
        '{kwm_pkg::KIND_POP,   3'd0, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 3'd7, 1'b0}},
        '{kwm_pkg::KIND_POP,   3'd0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 3'd0, 1'b1}},
        // list 2 pushed out of order
        '{kwm_pkg::KIND_PUSH,  3'd2, 32'd10,        1'b0, '{32'h0, 3'd0, 1'b0}},
        '{kwm_pkg::KIND_PUSH,  3'd2, 32'd5,         1'b0, '{32'h0, 3'd0, 1'b0}},
        '{kwm_pkg::KIND_PUSH,  3'd1, 32'd7,         1'b0, '{32'h0, 3'd0, 1'b0}},
        '{kwm_pkg::KIND_POP,   3'd0, 32'h0000_0000, 1'b0, '{32'h0, 3'd0, 1'b0}},
        '{kwm_pkg::KIND_POP,   3'd0, 32'h0000_0000, 1'b0, '{32'h0, 3'd0, 1'b0}},
        '{kwm_pkg::KIND_POP,   3'd0, 32'h0000_0000, 1'b0, '{32'h0, 3'd0, 1'b0}},
        '{kwm_pkg::KIND_PUSH,  3'd4, 32'd1,         1'b0, '{32'h0, 3'd0, 1'b0}},
        '{kwm_pkg::KIND_PUSH,  3'd6, 32'h5555_AAAA, 1'b0, '{32'h0, 3'd0, 1'b0}},
        '{kwm_pkg::KIND_CLEAR, 3'd0, 32'h0000_0000, 1'b0, '{32'h0, 3'd0, 1'b0}},
        '{kwm_pkg::KIND_POP,   3'd0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 3'd0, 1'b1}},
        '{kwm_pkg::KIND_PUSH,  3'd6, 32'hAAAA_5555, 1'b0, '{32'h0, 3'd0, 1'b0}}
    };

    k_way_sorted_merge dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    // Predicts one command; returns 1 when it yields a pop result.
    function automatic bit merge_step(input kwm_pkg::kind_t k, input logic [2:0] idx,
                                      input logic [31:0] v, output merge_out_t r);
        bit                 found;
        int                 best;
        logic signed [31:0] head;
        logic signed [31:0] best_val;
        found = 1'b0;
        best = 0;
        best_val = '0;
        r = '{32'h0, 3'd0, 1'b1};
        if (k != kwm_pkg::KIND_NONE)
            n_cmds++;
        case (k)
            kwm_pkg::KIND_PUSH:
            begin
                if (int'(idx) < kwm_pkg::NUM_LISTS && push_cnt[idx] < kwm_pkg::LIST_DEPTH)
                begin
                    list_mem[idx][push_cnt[idx]] = v;
                    push_cnt[idx]++;
                end
                else
                    n_drops++;
                return 1'b0;
            end
            kwm_pkg::KIND_CLEAR:
            begin
                for (int l = 0; l < kwm_pkg::NUM_LISTS; l++)
                begin
                    push_cnt[l] = 0;
                    pop_cnt[l] = 0;
                end
                n_clears++;
                return 1'b0;
            end
            kwm_pkg::KIND_POP:
            begin
                for (int l = 0; l < kwm_pkg::NUM_LISTS; l++)
                begin
                    if (pop_cnt[l] < push_cnt[l])
                    begin
                        head = list_mem[l][pop_cnt[l]];
                        if (!found || head < best_val)
                        begin
                            found = 1'b1;
                            best = l;
                            best_val = head;
                        end
                    end
                end
                n_pops++;
                if (found)
                begin
                    pop_cnt[best]++;
                    r = '{best_val, 3'(best), 1'b0};
                end
                else
                    n_empty_pops++;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic int unread_total();
        int sum;
        sum = 0;
        for (int l = 0; l < kwm_pkg::NUM_LISTS; l++)
            sum += push_cnt[l] - pop_cnt[l];
        return sum;
    endfunction

    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_cmd(input kwm_pkg::kind_t k, input logic [2:0] idx,
                            input logic [31:0] v);
        if (idle_en && $urandom_range(0, 99) < 8)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, v, idx, k};
        // s_tready settles between edges; sample it mid-cycle
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic issue(input kwm_pkg::kind_t k, input logic [2:0] idx,
                         input logic [31:0] v);
        merge_out_t r;
        send_cmd(k, idx, v);
        if (merge_step(k, idx, v, r))
            pop_results_q.push_back(r);
        if (k == kwm_pkg::KIND_CLEAR)
            seq_started = '{default: 1'b0};
    endtask

    task automatic push_next(input logic [2:0] idx);
        longint nxt;
        if (!seq_started[idx])
        begin
            // a narrow start range now and then makes ties across lists
            if ($urandom_range(0, 3) == 0)
                nxt = longint'($urandom_range(0, 15)) - 8;
            else
                nxt = longint'($signed($urandom));
            seq_started[idx] = 1'b1;
        end
        else
        begin
            nxt = longint'(seq_last[idx]) + longint'($urandom_range(0, 1 << $urandom_range(0, 24)));
            if (nxt > 64'sd2147483647)
                nxt = seq_last[idx];
        end
        seq_last[idx] = int'(nxt);
        issue(kwm_pkg::KIND_PUSH, idx, 32'(nxt));
    endtask

    task automatic noise_cmd();
        issue(kwm_pkg::kind_t'($urandom_range(0, 3)), 3'($urandom), $urandom);
    endtask

    task automatic pop_until_empty();
        repeat (unread_total() + 1)
            issue(kwm_pkg::KIND_POP, 3'($urandom), $urandom);
    endtask

    // hold off the sender until every pop result is back
    task automatic wait_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pop_results_q.size() != 0);
    endtask

    // sink side: random backpressure, result check
    always @(posedge clk)
        m_tready <= !idle_en || ($urandom_range(0, 99) >= 8);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (pop_results_q.size() == 0)
            begin
                $error("unexpected result: smallest_value %h source_list %0d all_empty %b",
                       m_tdata[31:0], m_tdata[34:32], m_tuser);
                errors++;
            end
            else
            begin
                mon_exp = pop_results_q.pop_front();
                if (m_tdata[31:0] !== mon_exp.value)
                begin
                    $error("smallest_value: expected %h, got %h", mon_exp.value, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[34:32] !== mon_exp.src)
                begin
                    $error("source_list: expected %0d, got %0d", mon_exp.src, m_tdata[34:32]);
                    errors++;
                end
                if (m_tuser !== mon_exp.empty)
                begin
                    $error("all_empty: expected %b, got %b", mon_exp.empty, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        merge_out_t  r;
        int          base;
        int          guard;
        int          n_push;
        int          n_lists;
        int          first;
        logic [2:0]  tgt;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        seq_started = '{default: 1'b0};
        seq_last    = '{default: 0};
        for (int l = 0; l < kwm_pkg::NUM_LISTS; l++)
        begin
            push_cnt[l] = 0;
            pop_cnt[l] = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        for (int i = 0; i < N_DIR; i++)
        begin
            send_cmd(dir_rows[i].kind, dir_rows[i].idx, dir_rows[i].val);
            if (merge_step(dir_rows[i].kind, dir_rows[i].idx, dir_rows[i].val, r))
            begin
                if (dir_rows[i].typed)
                    pop_results_q.push_back(dir_rows[i].res);
                else
                    pop_results_q.push_back(r);
            end
        end
        wait_results();

        // random part: episodes of ascending pushes and pops, with some noise
        base = n_cmds;
        first = 1;
        while (n_cmds - base < RAND_CMDS)
        begin
            idle_en = !((n_cmds - base) inside {[350:520]});
            if (first || $urandom_range(0, 7) == 0)
            begin
                // clear, then push more than one list's depth, mostly into one list
                first = 0;
                tgt = 3'($urandom);
                issue(kwm_pkg::KIND_CLEAR, 3'($urandom), $urandom);
                repeat (kwm_pkg::LIST_DEPTH + $urandom_range(1, 3))
                begin
                    if ($urandom_range(0, 9) == 0)
                        push_next(3'($urandom));
                    else
                        push_next(tgt);
                end
                pop_until_empty();
            end
            else
            begin
                if ($urandom_range(0, 4) != 0)
                    issue(kwm_pkg::KIND_CLEAR, 3'($urandom), $urandom);
                n_push  = $urandom_range(1, 48);
                n_lists = $urandom_range(1, 8);
                tgt     = 3'($urandom);
                repeat (n_push)
                begin
                    if ($urandom_range(0, 9) == 0)
                        noise_cmd();
                    else if ($urandom_range(0, 3) == 0)
                        issue(kwm_pkg::KIND_POP, 3'($urandom), $urandom);
                    else
                        push_next(tgt + 3'($urandom_range(0, n_lists - 1)));
                end
                pop_until_empty();
            end
            if ($urandom_range(0, 3) == 0)
                wait_results();
        end

        s_tvalid <= 1'b0;
        guard = 0;
        while (pop_results_q.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (pop_results_q.size() != 0)
        begin
            $error("%0d pop results never arrived", pop_results_q.size());
            errors++;
        end

        $display("Run covered %0d commands: %0d pops (%0d with all lists empty), %0d clears,",
                 n_cmds, n_pops, n_empty_pops, n_clears);
        $display("%0d pushes dropped on full lists, %0d results checked.", n_drops, n_results);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
